FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the ID generator.
// Expects a clock named clk and an active-low reset named rst_n in scope.
// Define ASSERT_OFF to compile all checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold on every clock edge outside reset.
`define CHK_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("property check failed");

// Expression must never be true outside reset.
`define CHK_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define CHK_PROP(lbl, prop)
`define CHK_NEVER(lbl, expr)

`endif

`endif

FILE: hw/rtl/uidg_pkg.sv
// Package for the unique ID generator: payload structs, register map,
// status codes and reset values. Used by unique_id_generator_drift_core.
package uidg_pkg;

  localparam int unsigned TIME_W    = 42;
  localparam int unsigned ID_W      = 64;
  localparam int unsigned SEQ_W     = 22;
  localparam int unsigned OCC_W     = 17;
  localparam int unsigned TBIDX_W   = 3;
  localparam int unsigned WORKER_W  = 20;
  localparam int unsigned FBITS_W   = 5;
  localparam int unsigned SEQCFG_W  = 21;
  localparam int unsigned TOPOC_W   = 16;
  localparam int unsigned LIMIT_W   = 32;
  localparam int unsigned PADDR_W   = 6;
  localparam int unsigned PDATA_W   = 64;

  typedef enum logic [2:0] {
    REG_DRIFT_MODE    = 3'd0,
    REG_BASE_TIME     = 3'd1,
    REG_WORKER_ID     = 3'd2,
    REG_WORKER_BITS   = 3'd3,
    REG_SEQ_BITS      = 3'd4,
    REG_MAX_SEQ       = 3'd5,
    REG_MIN_SEQ       = 3'd6,
    REG_TOP_OVER_COST = 3'd7
  } uidg_reg_t;

  localparam logic MODE_CLOCK   = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_BUSY = 1'b1;

  localparam logic [TBIDX_W-1:0] TB_IDX_MAX = 3'd4;
  localparam logic [TBIDX_W-1:0] TB_IDX_MIN = 3'd1;

  localparam logic                RST_DRIFT_MODE    = 1'b1;
  localparam logic [TIME_W-1:0]   RST_BASE_TIME     = 42'd1582136402000;
  localparam logic [WORKER_W-1:0] RST_WORKER_ID     = '0;
  localparam logic [FBITS_W-1:0]  RST_WORKER_BITS   = 5'd6;
  localparam logic [FBITS_W-1:0]  RST_SEQ_BITS      = 5'd6;
  localparam logic [SEQCFG_W-1:0] RST_MAX_SEQ       = '0;
  localparam logic [SEQCFG_W-1:0] RST_MIN_SEQ       = 21'd5;
  localparam logic [TOPOC_W-1:0]  RST_TOP_OVER_COST = 16'd2000;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] now_ms;
  } uidg_in_t;

  typedef struct packed {
    logic [ID_W-1:0] id_value;
    logic            status;
  } uidg_out_t;

endpackage

FILE: hw/rtl/unique_id_generator_drift_core.sv
// An accepted input is held in the input register; when the result register is free or
// being taken, the state update and ID assembly load the result register from it.
// Throughput: one item per cycle while out_ready is high; state update, 64-bit
// shift and add sit in one stage. Reset (rst_n, synchronous) loads register
// defaults and resets generator state; in_ready is high as soon as reset is released.
// Depends on uidg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module unique_id_generator_drift_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  uidg_pkg::uidg_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output uidg_pkg::uidg_out_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [uidg_pkg::PADDR_W-1:0]     paddr,
  input  logic [uidg_pkg::PDATA_W-1:0]     pwdata,
  output logic [uidg_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import uidg_pkg::*;

  // configuration registers
  logic                drift_mode_r;
  logic [TIME_W-1:0]   base_time_r;
  logic [WORKER_W-1:0] worker_id_r;
  logic [FBITS_W-1:0]  worker_bits_r;
  logic [FBITS_W-1:0]  seq_bits_r;
  logic [SEQCFG_W-1:0] max_seq_r;
  logic [SEQCFG_W-1:0] min_seq_r;
  logic [TOPOC_W-1:0]  top_oc_r;

  // input stage
  logic                stg_valid_r, stg_valid_nxt;
  logic                stg_mode_r;
  logic [TIME_W-1:0]   stg_tick_r;
  logic [TIME_W-1:0]   in_tick;

  // generator state
  logic [ID_W-1:0]     last_tick_r, last_tick_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic                ocf_r, ocf_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [ID_W-1:0]     tb_tick_r, tb_tick_nxt;
  logic [TBIDX_W-1:0]  tb_idx_r, tb_idx_nxt;
  logic                pend_r, pend_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  uidg_out_t           out_data_r, out_data_nxt;

  logic                proc_go;
  logic                res_make;
  logic                res_busy;
  logic                fmt_classic;
  logic [ID_W-1:0]     id_tick;
  logic [SEQ_W-1:0]    id_low;
  logic [ID_W-1:0]     tick64;
  logic [ID_W-1:0]     last_inc;
  logic [SEQ_W-1:0]    seq_inc;
  logic [SEQ_W-1:0]    min_ext;
  logic [SEQ_W-1:0]    min_inc;
  logic [LIMIT_W-1:0]  seq_limit;
  logic [ID_W-1:0]     tb_cur;
  logic [TBIDX_W-1:0]  idx_inc;
  logic [TBIDX_W-1:0]  idx_cur;
  logic [5:0]          tick_sh;
  logic [ID_W-1:0]     tick_part;
  logic [ID_W-1:0]     worker_part;
  logic [ID_W-1:0]     low_part;
  logic                cfg_wr;
  uidg_reg_t           cfg_idx;
  logic                out_busy;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = uidg_reg_t'(paddr[PADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_mode_r  <= RST_DRIFT_MODE;
      base_time_r   <= RST_BASE_TIME;
      worker_id_r   <= RST_WORKER_ID;
      worker_bits_r <= RST_WORKER_BITS;
      seq_bits_r    <= RST_SEQ_BITS;
      max_seq_r     <= RST_MAX_SEQ;
      min_seq_r     <= RST_MIN_SEQ;
      top_oc_r      <= RST_TOP_OVER_COST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DRIFT_MODE:    drift_mode_r  <= pwdata[0];
        REG_BASE_TIME:     base_time_r   <= pwdata[TIME_W-1:0];
        REG_WORKER_ID:     worker_id_r   <= pwdata[WORKER_W-1:0];
        REG_WORKER_BITS:   worker_bits_r <= pwdata[FBITS_W-1:0];
        REG_SEQ_BITS:      seq_bits_r    <= pwdata[FBITS_W-1:0];
        REG_MAX_SEQ:       max_seq_r     <= pwdata[SEQCFG_W-1:0];
        REG_MIN_SEQ:       min_seq_r     <= pwdata[SEQCFG_W-1:0];
        REG_TOP_OVER_COST: top_oc_r      <= pwdata[TOPOC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DRIFT_MODE:    prdata = {{(PDATA_W-1){1'b0}}, drift_mode_r};
      REG_BASE_TIME:     prdata = {{(PDATA_W-TIME_W){1'b0}}, base_time_r};
      REG_WORKER_ID:     prdata = {{(PDATA_W-WORKER_W){1'b0}}, worker_id_r};
      REG_WORKER_BITS:   prdata = {{(PDATA_W-FBITS_W){1'b0}}, worker_bits_r};
      REG_SEQ_BITS:      prdata = {{(PDATA_W-FBITS_W){1'b0}}, seq_bits_r};
      REG_MAX_SEQ:       prdata = {{(PDATA_W-SEQCFG_W){1'b0}}, max_seq_r};
      REG_MIN_SEQ:       prdata = {{(PDATA_W-SEQCFG_W){1'b0}}, min_seq_r};
      REG_TOP_OVER_COST: prdata = {{(PDATA_W-TOPOC_W){1'b0}}, top_oc_r};
      default:           prdata = '0;
    endcase
  end

  // ---------------- input stage ----------------
  // tick = now - base, clamped at zero; taken at the input transfer
  assign in_tick  = (in_data.now_ms > base_time_r) ? (in_data.now_ms - base_time_r) : '0;
  assign proc_go  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || proc_go;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (proc_go) begin
      stg_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      stg_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_mode_r <= in_data.mode;
      stg_tick_r <= in_tick;
    end
  end

  // ---------------- generator update ----------------
  assign tick64    = {{(ID_W-TIME_W){1'b0}}, stg_tick_r};
  assign last_inc  = last_tick_r + 64'd1;
  assign seq_inc   = seq_r + 22'd1;
  assign min_ext   = {1'b0, min_seq_r};
  assign min_inc   = min_ext + 22'd1;
  assign seq_limit = (max_seq_r != '0) ? {{(LIMIT_W-SEQCFG_W){1'b0}}, max_seq_r}
                                       : ((32'd1 << seq_bits_r) - 32'd1);
  // turnback: a fresh episode starts one tick below last_tick, index cycles 1..4
  assign tb_cur  = (tb_tick_r == '0) ? (last_tick_r - 64'd1) : tb_tick_r;
  assign idx_inc = tb_idx_r + 3'd1;
  assign idx_cur = (tb_tick_r != '0) ? tb_idx_r :
                   (idx_inc > TB_IDX_MAX) ? TB_IDX_MIN : idx_inc;

  always_comb begin
    last_tick_nxt = last_tick_r;
    seq_nxt       = seq_r;
    ocf_nxt       = ocf_r;
    occ_nxt       = occ_r;
    tb_tick_nxt   = tb_tick_r;
    tb_idx_nxt    = tb_idx_r;
    pend_nxt      = pend_r;
    res_make      = 1'b0;
    res_busy      = 1'b0;
    fmt_classic   = 1'b0;
    id_tick       = last_tick_r;
    id_low        = seq_r;
    if (proc_go) begin
      if (stg_mode_r == MODE_CLOCK) begin
        if (pend_r && (tick64 > last_tick_r)) begin
          pend_nxt      = 1'b0;
          last_tick_nxt = tick64;
          res_make      = 1'b1;
          id_tick       = tick64;
          id_low        = min_ext;
          if (drift_mode_r) begin
            ocf_nxt = 1'b0;
            occ_nxt = '0;
            seq_nxt = min_inc;
          end else begin
            seq_nxt     = min_ext;
            fmt_classic = 1'b1;
          end
        end
      end else if (pend_r) begin
        res_make = 1'b1;
        res_busy = 1'b1;
      end else if (drift_mode_r) begin
        if (ocf_r) begin
          if (tick64 > last_tick_r) begin
            last_tick_nxt = tick64;
            ocf_nxt       = 1'b0;
            occ_nxt       = '0;
            res_make      = 1'b1;
            id_tick       = tick64;
            id_low        = min_ext;
            seq_nxt       = min_inc;
          end else if (occ_r > {1'b0, top_oc_r}) begin
            pend_nxt = 1'b1;
          end else if ({10'd0, seq_r} > seq_limit) begin
            last_tick_nxt = last_inc;
            occ_nxt       = occ_r + 17'd1;
            res_make      = 1'b1;
            id_tick       = last_inc;
            id_low        = min_ext;
            seq_nxt       = min_inc;
          end else begin
            res_make = 1'b1;
            seq_nxt  = seq_inc;
          end
        end else begin
          res_make = 1'b1;
          if (tick64 < last_tick_r) begin
            id_tick     = tb_cur;
            id_low      = {{(SEQ_W-TBIDX_W){1'b0}}, idx_cur};
            tb_tick_nxt = tb_cur - 64'd1;
            tb_idx_nxt  = idx_cur;
          end else begin
            tb_tick_nxt = '0;
            if (tick64 > last_tick_r) begin
              last_tick_nxt = tick64;
              id_tick       = tick64;
              id_low        = min_ext;
              seq_nxt       = min_inc;
            end else if ({10'd0, seq_r} > seq_limit) begin
              last_tick_nxt = last_inc;
              ocf_nxt       = 1'b1;
              occ_nxt       = 17'd1;
              id_tick       = last_inc;
              id_low        = min_ext;
              seq_nxt       = min_inc;
            end else begin
              seq_nxt = seq_inc;
            end
          end
        end
      end else begin
        // classic: sequence runs within a tick, restarts on a new one
        last_tick_nxt = tick64;
        fmt_classic   = 1'b1;
        id_tick       = tick64;
        if (last_tick_r == tick64) begin
          if ({10'd0, seq_inc} > seq_limit) begin
            seq_nxt  = min_ext;
            pend_nxt = 1'b1;
          end else begin
            seq_nxt  = seq_inc;
            res_make = 1'b1;
            id_low   = seq_inc;
          end
        end else begin
          seq_nxt  = min_ext;
          res_make = 1'b1;
          id_low   = min_ext;
        end
      end
    end
  end

  // ---------------- ID assembly ----------------
  assign tick_sh     = {1'b0, worker_bits_r} + {1'b0, seq_bits_r};
  assign tick_part   = id_tick << tick_sh;
  assign worker_part = {{(ID_W-WORKER_W){1'b0}}, worker_id_r} << seq_bits_r;
  assign low_part    = {{(ID_W-SEQ_W){1'b0}}, id_low};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (proc_go) begin
      out_valid_nxt = res_make;
      if (res_busy) begin
        out_data_nxt.id_value = '0;
        out_data_nxt.status   = STATUS_BUSY;
      end else begin
        out_data_nxt.id_value = fmt_classic ? (tick_part | worker_part | low_part)
                                            : (tick_part + worker_part + low_part);
        out_data_nxt.status   = STATUS_OK;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tick_r <= '0;
      seq_r       <= {1'b0, RST_MIN_SEQ};
      ocf_r       <= 1'b0;
      occ_r       <= '0;
      tb_tick_r   <= '0;
      tb_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      last_tick_r <= last_tick_nxt;
      seq_r       <= seq_nxt;
      ocf_r       <= ocf_nxt;
      occ_r       <= occ_nxt;
      tb_tick_r   <= tb_tick_nxt;
      tb_idx_r    <= tb_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  assign out_busy = out_valid_r && (out_data_r.status == STATUS_BUSY);

  `CHK_PROP(a_busy_zero_id, out_busy |-> (out_data_r.id_value == '0))
  `CHK_NEVER(a_tb_idx_range, tb_idx_r > TB_IDX_MAX)
  `CHK_PROP(a_occ_needs_flag, !ocf_r |-> (occ_r == '0))
  `CHK_PROP(a_pend_no_result, $rose(pend_r) |-> ($past(proc_go) && !$past(res_make)))

endmodule

FILE: tb/sv/unique_id_generator_drift_core_tb.sv
// Testbench for unique_id_generator_drift_core: directed and random ID requests and
// clock updates, checked against an in-bench model of the drift and classic algorithms.
// Depends on uidg_pkg; drives the APB-style register port to change settings between phases.
module unique_id_generator_drift_core_tb;
  import uidg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 200;
  localparam int          LONG_HOLD   = 300;
  localparam int          SETTLE      = 8;
  localparam logic [TIME_W-1:0] NEAR_TOP_MS = 42'h3FF_FFFF_FF00;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  uidg_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  uidg_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  unique_id_generator_drift_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // register shadow
  logic                cur_drift_mode  = RST_DRIFT_MODE;
  logic [TIME_W-1:0]   cur_base_time   = RST_BASE_TIME;
  logic [WORKER_W-1:0] cur_worker_id   = RST_WORKER_ID;
  logic [FBITS_W-1:0]  cur_worker_bits = RST_WORKER_BITS;
  logic [FBITS_W-1:0]  cur_seq_bits    = RST_SEQ_BITS;
  logic [SEQCFG_W-1:0] cur_max_seq     = RST_MAX_SEQ;
  logic [SEQCFG_W-1:0] cur_min_seq     = RST_MIN_SEQ;
  logic [TOPOC_W-1:0]  cur_top_oc      = RST_TOP_OVER_COST;

  // generator state as the block should hold it
  logic [ID_W-1:0]    gen_last_tick = '0;
  logic [SEQ_W-1:0]   gen_seq       = SEQ_W'(RST_MIN_SEQ);
  logic               gen_oc_flag   = 1'b0;
  logic [OCC_W-1:0]   gen_oc_count  = '0;
  logic [ID_W-1:0]    gen_tb_tick   = '0;
  logic [TBIDX_W-1:0] gen_tb_idx    = '0;
  logic               gen_pending   = 1'b0;

  uidg_out_t   id_expect_q[$];
  int          err_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        idle_on = 1'b0;
  int          hold_asked = 0;
  int          hold_taken = 0;
  int          hold_left = 0;

  function automatic logic [63:0] seq_ceiling();
    if (cur_max_seq != 0) return 64'(cur_max_seq);
    return (64'd1 << cur_seq_bits) - 64'd1;
  endfunction

  function automatic logic [63:0] worker_field();
    return 64'(cur_worker_id) << cur_seq_bits;
  endfunction

  function automatic logic [63:0] tick_field(input logic [63:0] t);
    return t << ({1'b0, cur_worker_bits} + {1'b0, cur_seq_bits});
  endfunction

  function automatic logic [63:0] drift_id();
    logic [63:0] v;
    v = tick_field(gen_last_tick) + worker_field() + 64'(gen_seq);
    gen_seq = gen_seq + 1'b1;
    return v;
  endfunction

  function automatic logic [63:0] classic_id();
    return tick_field(gen_last_tick) | worker_field() | 64'(gen_seq);
  endfunction

  // Advances the generator by one item; returns 1 when the item yields a result.
  function automatic logic predict_id(input uidg_in_t item, output uidg_out_t res);
    logic [63:0] tick;
    logic        made;
    tick = (item.now_ms > cur_base_time) ? 64'(item.now_ms - cur_base_time) : 64'd0;
    res.id_value = '0;
    res.status = STATUS_OK;
    made = 1'b1;
    if (item.mode == MODE_CLOCK) begin
      if (!gen_pending || tick <= gen_last_tick) return 1'b0;
      gen_pending = 1'b0;
      gen_last_tick = tick;
      gen_seq = SEQ_W'(cur_min_seq);
      if (cur_drift_mode) begin
        gen_oc_flag = 1'b0;
        gen_oc_count = '0;
        res.id_value = drift_id();
      end else begin
        res.id_value = classic_id();
      end
      return 1'b1;
    end
    if (gen_pending) begin
      res.status = STATUS_BUSY;
      return 1'b1;
    end
    if (cur_drift_mode && gen_oc_flag) begin
      if (tick > gen_last_tick) begin
        gen_last_tick = tick;
        gen_seq = SEQ_W'(cur_min_seq);
        gen_oc_flag = 1'b0;
        gen_oc_count = '0;
        res.id_value = drift_id();
      end else if (gen_oc_count > OCC_W'(cur_top_oc)) begin
        gen_pending = 1'b1;
        made = 1'b0;
      end else begin
        // sequence spent: borrow one more future tick
        if (64'(gen_seq) > seq_ceiling()) begin
          gen_last_tick = gen_last_tick + 1;
          gen_seq = SEQ_W'(cur_min_seq);
          gen_oc_flag = 1'b1;
          gen_oc_count = gen_oc_count + 1'b1;
        end
        res.id_value = drift_id();
      end
    end else if (cur_drift_mode) begin
      if (tick < gen_last_tick) begin
        // clock went back: count down below last_tick, tagged with the turnback index
        if (gen_tb_tick == 0) begin
          gen_tb_tick = gen_last_tick - 1;
          gen_tb_idx = gen_tb_idx + 1'b1;
          if (gen_tb_idx > TB_IDX_MAX) gen_tb_idx = TB_IDX_MIN;
        end
        res.id_value = tick_field(gen_tb_tick) + worker_field() + 64'(gen_tb_idx);
        gen_tb_tick = gen_tb_tick - 1;
      end else begin
        gen_tb_tick = '0;
        if (tick > gen_last_tick) begin
          gen_last_tick = tick;
          gen_seq = SEQ_W'(cur_min_seq);
        end else if (64'(gen_seq) > seq_ceiling()) begin
          gen_last_tick = gen_last_tick + 1;
          gen_seq = SEQ_W'(cur_min_seq);
          gen_oc_flag = 1'b1;
          gen_oc_count = OCC_W'(1);
        end
        res.id_value = drift_id();
      end
    end else begin
      if (gen_last_tick == tick) begin
        gen_seq = gen_seq + 1'b1;
        if (64'(gen_seq) > seq_ceiling()) begin
          gen_seq = SEQ_W'(cur_min_seq);
          gen_pending = 1'b1;
          made = 1'b0;
        end
      end else begin
        gen_seq = SEQ_W'(cur_min_seq);
      end
      if (made) begin
        gen_last_tick = tick;
        res.id_value = classic_id();
      end
    end
    return made;
  endfunction

  function automatic uidg_in_t make_item(input logic kind, input logic [TIME_W-1:0] now);
    uidg_in_t it;
    it.mode = kind;
    it.now_ms = now;
    return it;
  endfunction

  function automatic logic [63:0] pick_in_range(input logic [63:0] lo, input logic [63:0] hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
    endcase
  endfunction

  task automatic report_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    err_cnt++;
    if (err_cnt <= 30)
      $display("ERROR %0d: %s got %h want %h (cycle %0d)", err_cnt, what, got, want, cycle_cnt);
  endtask

  // Holds one item on the input until the transfer, then predicts its result.
  task automatic send_item(input uidg_in_t item);
    uidg_out_t res;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (predict_id(item, res)) id_expect_q.push_back(res);
  endtask

  // Writes one register: setup phase, access phase, then the bus goes idle before the task returns.
  task automatic write_reg(input uidg_reg_t idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DRIFT_MODE:    cur_drift_mode  = value[0];
      REG_BASE_TIME:     cur_base_time   = value[TIME_W-1:0];
      REG_WORKER_ID:     cur_worker_id   = value[WORKER_W-1:0];
      REG_WORKER_BITS:   cur_worker_bits = value[FBITS_W-1:0];
      REG_SEQ_BITS:      cur_seq_bits    = value[FBITS_W-1:0];
      REG_MAX_SEQ:       cur_max_seq     = value[SEQCFG_W-1:0];
      REG_MIN_SEQ:       cur_min_seq     = value[SEQCFG_W-1:0];
      REG_TOP_OVER_COST: cur_top_oc      = value[TOPOC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering, wait for every expected result, then let a pending item finish.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (id_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    wait_quiet();
    send_item(make_item(MODE_REQUEST, '0));  // tick clamps to zero
    send_item(make_item(MODE_REQUEST, '1));
    send_item(make_item(MODE_CLOCK, '0));    // nothing pending: no result
  endtask

  task automatic test_drift_borrow();
    wait_quiet();
    write_reg(REG_BASE_TIME, 64'd0);
    write_reg(REG_WORKER_ID, 64'hF_FFFF);
    write_reg(REG_WORKER_BITS, 64'd20);
    write_reg(REG_SEQ_BITS, 64'd2);
    write_reg(REG_MAX_SEQ, 64'd0);
    write_reg(REG_MIN_SEQ, 64'd5);
    write_reg(REG_TOP_OVER_COST, 64'd1);
    // min_seq above the limit: every repeat borrows a tick until the budget runs out
    repeat (4) send_item(make_item(MODE_REQUEST, NEAR_TOP_MS));
    send_item(make_item(MODE_REQUEST, NEAR_TOP_MS));
    send_item(make_item(MODE_CLOCK, NEAR_TOP_MS));
    send_item(make_item(MODE_CLOCK, NEAR_TOP_MS + TIME_W'(5)));
  endtask

  task automatic test_turnback_index();
    wait_quiet();
    send_item(make_item(MODE_REQUEST, NEAR_TOP_MS));
    send_item(make_item(MODE_REQUEST, NEAR_TOP_MS));
    // forward then back again; the fourth pass of the loop wraps the index back to 1
    for (int i = 1; i <= 4; i++) begin
      send_item(make_item(MODE_REQUEST, NEAR_TOP_MS + TIME_W'(10 * i)));
      send_item(make_item(MODE_REQUEST, NEAR_TOP_MS + TIME_W'(10 * i - 5)));
    end
  endtask

  task automatic test_classic_wait();
    wait_quiet();
    write_reg(REG_DRIFT_MODE, 64'd0);
    write_reg(REG_BASE_TIME, 64'h3FF_FFFF_FFFF);
    write_reg(REG_SEQ_BITS, 64'd3);
    write_reg(REG_MAX_SEQ, 64'd7);
    repeat (4) send_item(make_item(MODE_REQUEST, NEAR_TOP_MS));
    send_item(make_item(MODE_REQUEST, NEAR_TOP_MS));
    send_item(make_item(MODE_CLOCK, '1));
    wait_quiet();
    write_reg(REG_BASE_TIME, 64'd0);
    send_item(make_item(MODE_CLOCK, TIME_W'(100)));
  endtask

  task automatic test_random_traffic();
    uidg_in_t          item;
    logic [TIME_W-1:0] now_cur;
    logic [63:0]       seq_lo;
    int                pick;
    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      if (p == 0) begin
        write_reg(REG_DRIFT_MODE, 64'd1);
        write_reg(REG_BASE_TIME, 64'd0);
        write_reg(REG_WORKER_ID, 64'd0);
        write_reg(REG_WORKER_BITS, 64'd1);
        write_reg(REG_SEQ_BITS, 64'd21);
        write_reg(REG_MAX_SEQ, 64'h1F_FFFF);
        write_reg(REG_MIN_SEQ, 64'h1F_FFFF);
        write_reg(REG_TOP_OVER_COST, 64'hFFFF);
      end else begin
        seq_lo = ($urandom_range(0, 3) != 0) ? 64'($urandom_range(5, 12))
                                              : pick_in_range(5, 64'h1F_FFFF);
        write_reg(REG_DRIFT_MODE, p[0] ? 64'd0 : 64'd1);
        write_reg(REG_BASE_TIME, ($urandom_range(0, 3) == 0) ? 64'd0
                                 : {$urandom_range(0, 511), $urandom});
        write_reg(REG_WORKER_ID, pick_in_range(0, 64'hF_FFFF));
        write_reg(REG_WORKER_BITS, pick_in_range(1, 20));
        write_reg(REG_SEQ_BITS, ($urandom_range(0, 2) != 0) ? 64'($urandom_range(2, 4))
                                : pick_in_range(2, 21));
        write_reg(REG_MIN_SEQ, seq_lo);
        case ($urandom_range(0, 2))
          0: write_reg(REG_MAX_SEQ, 64'd0);
          1: write_reg(REG_MAX_SEQ, (seq_lo + $urandom_range(0, 4)) & 64'h1F_FFFF);
          default: write_reg(REG_MAX_SEQ, pick_in_range(0, 64'h1F_FFFF));
        endcase
        write_reg(REG_TOP_OVER_COST, ($urandom_range(0, 3) != 0)
                  ? 64'($urandom_range(1, 4)) : pick_in_range(1, 64'hFFFF));
      end
      if (p == 2) hold_asked <= hold_asked + 1;
      // resume at or just past the last tick under the new epoch
      now_cur = TIME_W'(64'(cur_base_time) + gen_last_tick + $urandom_range(0, 2));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        item.mode = MODE_REQUEST;
        if (pick < 50) begin
          // same millisecond: runs the sequence out
        end else if (pick < 70) begin
          now_cur = now_cur + TIME_W'($urandom_range(1, 3));
        end else if (pick < 72) begin
          now_cur = now_cur + TIME_W'($urandom_range(4, 100000));
        end else if (pick < 84) begin
          now_cur = now_cur + TIME_W'($urandom_range(0, 2));
          item.mode = MODE_CLOCK;
        end else if (pick < 94 && now_cur > TIME_W'(8)) begin
          now_cur = now_cur - TIME_W'($urandom_range(1, 5));
        end
        item.now_ms = now_cur;
        if (pick >= 94) begin
          item.mode = ($urandom_range(0, 1) != 0) ? MODE_REQUEST : MODE_CLOCK;
          item.now_ms = TIME_W'({$urandom, $urandom} % (64'(now_cur) + 64'd1));
        end
        send_item(item);
        if (idle_on && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end
  endtask

  // result side: random stall bursts plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    uidg_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (id_expect_q.size() == 0) begin
        report_error("unexpected transfer", out_data.id_value, '0);
      end else begin
        want = id_expect_q.pop_front();
        if (out_data.status !== want.status)
          report_error("status", 64'(out_data.status), 64'(want.status));
        if (out_data.id_value !== want.id_value)
          report_error("id_value", out_data.id_value, want.id_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("unique_id_generator_drift_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_drift_borrow();
    test_turnback_index();
    test_classic_wait();
    test_random_traffic();
    wait_quiet();
    if (err_cnt == 0) begin
      $display("unique_id_generator_drift_core: match");
    end else begin
      $display("unique_id_generator_drift_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: unique_id_generator_drift_core.f
+incdir+hw/rtl
hw/rtl/uidg_pkg.sv
hw/rtl/unique_id_generator_drift_core.sv
tb/sv/unique_id_generator_drift_core_tb.sv
